### hw/rtl/cpct_pkg.sv
// Shared constants and the sine table builder for the Clarke/Park current transform.
package cpct_pkg;

  // Width of a current sample and of the d/q results.
  localparam int SAMPLE_BITS = 16;

  // Default number of table steps in one quarter wave.
  localparam int SINE_TABLE_DEPTH = 1024;

  // Width of a signed Q1.15 sine or cosine value.
  localparam int TRIG_W = 16;

  // 1/sqrt(3) in Q15.
  localparam logic signed [15:0] INV_SQRT3_Q15 = 16'sd18919;

  // pi/2 in Q30, used to place the table points on the quarter wave.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Rounding offset for a right shift by 15.
  localparam int ROUND_Q15 = 16384;

  // Sine of a Q30 angle by a nine-term Taylor series, returned as an
  // unsigned Q15 magnitude clamped to 32767. Evaluated at elaboration only.
  function automatic logic [14:0] sine_q15(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          e;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = longint'(((64'(sum)) * 64'd32768 + 64'd536870912) >> 30);
    if (e > 32767) begin
      e = 32767;
    end
    return e[14:0];
  endfunction

endpackage

### hw/rtl/clarke_park_current_transform.sv
// Top level: pipelined two-phase Clarke transform followed by a Park rotation.
//
//  channel  | direction | tdata fields (low bit first)                 | tuser
//  ---------+-----------+----------------------------------------------+------
//  in_      | slave     | phase_a[15:0], phase_b[31:16], angle[47:32]  | none
//  out_     | master    | d_current[15:0], q_current[31:16]            | none
//
// One beat can enter in every cycle while the output is not stalled; the depth is
// set by the sine table read and the two rounds of multipliers (Clarke
// coefficient, then the four Park products).
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage holds its beat while the next one is full and stalled, so a stall
// at the output backs up stage by stage and empty stages still fill up.
module clarke_park_current_transform #(
  parameter int SINE_TABLE_DEPTH = cpct_pkg::SINE_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // phase_a[15:0], phase_b[31:16], angle[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // d_current[15:0], q_current[31:16]
);

  localparam int SB      = cpct_pkg::SAMPLE_BITS;
  localparam int TW      = cpct_pkg::TRIG_W;
  localparam int NSTAGE  = 6;
  // Angle to table position.
  localparam int PW      = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int PRDW    = 16 + PW + 1;
  localparam int AW      = $clog2(SINE_TABLE_DEPTH + 1);
  // Datapath widths.
  localparam int ABW     = SB + 2;
  localparam int BPRODW  = ABW + 16;
  localparam int BETAW   = BPRODW - 14;
  localparam int PRODW   = BETAW + TW;
  localparam int SUMW    = PRODW + 1;
  localparam int RNDW    = SUMW - 14;

  localparam logic [PRDW-1:0] ANGLE_SCALE = PRDW'(4 * SINE_TABLE_DEPTH);
  localparam logic [PW-1:0]   QUAD1 = PW'(SINE_TABLE_DEPTH);
  localparam logic [PW-1:0]   QUAD2 = PW'(2 * SINE_TABLE_DEPTH);
  localparam logic [PW-1:0]   QUAD3 = PW'(3 * SINE_TABLE_DEPTH);
  localparam logic [AW-1:0]   TOP_ADDR = AW'(SINE_TABLE_DEPTH);
  localparam logic signed [RNDW-1:0] SAT_HI = RNDW'((1 << (SB - 1)) - 1);
  localparam logic signed [RNDW-1:0] SAT_LO = -RNDW'(1 << (SB - 1));

  // Quarter-wave sine table, one entry past the quarter point.
  logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned XI =
      (cpct_pkg::HALF_PI_Q30 * gi + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
    assign sine_rom[gi] = cpct_pkg::sine_q15(XI);
  end

  // Stage valid bits and per-stage advance.
  logic [NSTAGE:1]   vld_r;
  logic [NSTAGE+1:1] adv;

  always_comb begin
    adv[NSTAGE+1] = out_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = adv[1];

  // Stage 1: unpack, form a + 2b, scale the angle to a table position.
  logic signed [SB-1:0]  a_in;
  logic signed [SB-1:0]  b_in;
  logic [PRDW-1:0]       p_prod;
  logic signed [SB-1:0]  a1_r;
  logic signed [ABW-1:0] ab1_r;
  logic [PW-1:0]         p1_r;

  assign a_in   = in_tdata[SB-1:0];
  assign b_in   = in_tdata[16+SB-1:16];
  assign p_prod = PRDW'(in_tdata[47:32]) * ANGLE_SCALE;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      a1_r  <= a_in;
      ab1_r <= ABW'(a_in) + (ABW'(b_in) <<< 1);
      p1_r  <= p_prod[PW+15:16];
    end
  end

  // Stage 2: Clarke coefficient product, quadrant decode and table read.
  logic [1:0]            quad;
  logic [PW-1:0]         quad_base;
  logic [AW-1:0]         offs;
  logic [1:0]            cos_quad;
  logic [AW-1:0]         sin_addr;
  logic [AW-1:0]         cos_addr;
  logic signed [SB-1:0]  a2_r;
  logic signed [BPRODW-1:0] bprod2_r;
  logic [14:0]           sin_mag2_r;
  logic [14:0]           cos_mag2_r;
  logic                  sin_neg2_r;
  logic                  cos_neg2_r;

  always_comb begin
    if (p1_r >= QUAD3) begin
      quad      = 2'd3;
      quad_base = QUAD3;
    end else if (p1_r >= QUAD2) begin
      quad      = 2'd2;
      quad_base = QUAD2;
    end else if (p1_r >= QUAD1) begin
      quad      = 2'd1;
      quad_base = QUAD1;
    end else begin
      quad      = 2'd0;
      quad_base = '0;
    end
    offs     = AW'(p1_r - quad_base);
    // Cosine is the sine one quadrant ahead at the same offset.
    cos_quad = quad + 2'd1;
    sin_addr = quad[0]     ? (TOP_ADDR - offs) : offs;
    cos_addr = cos_quad[0] ? (TOP_ADDR - offs) : offs;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      a2_r       <= a1_r;
      bprod2_r   <= BPRODW'(ab1_r) * BPRODW'(cpct_pkg::INV_SQRT3_Q15);
      sin_mag2_r <= sine_rom[sin_addr];
      cos_mag2_r <= sine_rom[cos_addr];
      sin_neg2_r <= quad[1];
      cos_neg2_r <= cos_quad[1];
    end
  end

  // Stage 3: round beta, give sine and cosine their signs.
  logic signed [BPRODW:0]  beta_t;
  logic signed [TW-1:0]    sin_pos;
  logic signed [TW-1:0]    cos_pos;
  logic signed [SB-1:0]    a3_r;
  logic signed [BETAW-1:0] beta3_r;
  logic signed [TW-1:0]    sin3_r;
  logic signed [TW-1:0]    cos3_r;

  assign beta_t  = (BPRODW+1)'(bprod2_r) + (BPRODW+1)'(cpct_pkg::ROUND_Q15);
  assign sin_pos = {1'b0, sin_mag2_r};
  assign cos_pos = {1'b0, cos_mag2_r};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      a3_r    <= a2_r;
      beta3_r <= beta_t[BPRODW:15];
      sin3_r  <= sin_neg2_r ? -sin_pos : sin_pos;
      cos3_r  <= cos_neg2_r ? -cos_pos : cos_pos;
    end
  end

  // Stage 4: the four rotation products.
  logic signed [PRODW-1:0] ac4_r;
  logic signed [PRODW-1:0] as4_r;
  logic signed [PRODW-1:0] bc4_r;
  logic signed [PRODW-1:0] bs4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ac4_r <= PRODW'(a3_r) * PRODW'(cos3_r);
      as4_r <= PRODW'(a3_r) * PRODW'(sin3_r);
      bc4_r <= PRODW'(beta3_r) * PRODW'(cos3_r);
      bs4_r <= PRODW'(beta3_r) * PRODW'(sin3_r);
    end
  end

  // Stage 5: combine the products into d and q at full width.
  logic signed [SUMW-1:0] d5_r;
  logic signed [SUMW-1:0] q5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d5_r <= SUMW'(ac4_r) + SUMW'(bs4_r);
      q5_r <= SUMW'(bc4_r) - SUMW'(as4_r);
    end
  end

  // Stage 6: round, saturate and hold the result beat.
  logic signed [SUMW:0]   d_t;
  logic signed [SUMW:0]   q_t;
  logic signed [RNDW-1:0] d_rnd;
  logic signed [RNDW-1:0] q_rnd;
  logic signed [SB-1:0]   d_sat;
  logic signed [SB-1:0]   q_sat;
  logic signed [SB-1:0]   d6_r;
  logic signed [SB-1:0]   q6_r;

  always_comb begin
    d_t   = (SUMW+1)'(d5_r) + (SUMW+1)'(cpct_pkg::ROUND_Q15);
    q_t   = (SUMW+1)'(q5_r) + (SUMW+1)'(cpct_pkg::ROUND_Q15);
    d_rnd = d_t[SUMW:15];
    q_rnd = q_t[SUMW:15];
    if (d_rnd > SAT_HI) begin
      d_sat = SB'(SAT_HI);
    end else if (d_rnd < SAT_LO) begin
      d_sat = SB'(SAT_LO);
    end else begin
      d_sat = SB'(d_rnd);
    end
    if (q_rnd > SAT_HI) begin
      q_sat = SB'(SAT_HI);
    end else if (q_rnd < SAT_LO) begin
      q_sat = SB'(SAT_LO);
    end else begin
      q_sat = SB'(q_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      d6_r <= d_sat;
      q6_r <= q_sat;
    end
  end

  assign out_tvalid = vld_r[NSTAGE];
  assign out_tdata  = {16'(q6_r), 16'(d6_r)};

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Input can only be held off by a full pipeline stalled at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // Sine and cosine of one angle lie on the unit circle.
  a_unit_circle: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |->
      ((longint'(sin3_r) * longint'(sin3_r) + longint'(cos3_r) * longint'(cos3_r))
         > 64'sd1073610752) &&
      ((longint'(sin3_r) * longint'(sin3_r) + longint'(cos3_r) * longint'(cos3_r))
         < 64'sd1073872896))
    else $error("sine and cosine quadrants disagree");

  // Beta stays within one bit of the sample width.
  a_beta_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (beta3_r >= -BETAW'(1 << SB)) && (beta3_r < BETAW'(1 << SB)))
    else $error("beta out of range");

endmodule

### sim/testbench.sv
// Self-checking stream testbench for the Clarke/Park current transform.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = cpct_pkg::SINE_TABLE_DEPTH;
  localparam int RANDOM_BEATS = 1350;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 12;

  // One input beat, phase_a in the low bits.
  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_a;
  } sample_t;

  // One result beat, d_current in the low bits.
  typedef struct packed {
    logic signed [15:0] q_current;
    logic signed [15:0] d_current;
  } dq_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  sample_t samples_to_send[$];
  dq_t     dq_expected[$];
  int      quarter_wave[0:DEPTH];

  int total_beats = 0;
  int beats_in = 0;
  int beats_out = 0;
  int rail_hits = 0;
  int error_count = 0;
  int hold_at = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tx_idle_pct;
  int rx_idle_pct;

  clarke_park_current_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Idle profile: slow receiver first, then slow sender, then full rate.
  assign tx_idle_pct = (beats_in < total_beats / 3) ? 6 :
                       (beats_in < 2 * total_beats / 3) ? 82 : 0;
  assign rx_idle_pct = (beats_in < total_beats / 3) ? 82 :
                       (beats_in < 2 * total_beats / 3) ? 6 : 0;

  // Table point i of the quarter wave: Q30 Taylor series, scaled to Q15.
  function automatic int quarter_sine(int idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          e;
    int              k;
    x    = (cpct_pkg::HALF_PI_Q30 * longint'(idx) + longint'(DEPTH / 2)) /
           longint'(DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (sum * 32768 + (64'sd1 << 29)) >>> 30;
    if (e > 32767) begin
      e = 32767;
    end
    return int'(e);
  endfunction

  // Signed sine at table position p, which covers one full turn in 4*DEPTH steps.
  function automatic longint sine_at_step(int p);
    int     quadrant;
    int     off;
    longint mag;
    quadrant = (p / DEPTH) & 3;
    off      = p % DEPTH;
    mag      = (quadrant & 1) ? quarter_wave[DEPTH - off] : quarter_wave[off];
    return (quadrant & 2) ? -mag : mag;
  endfunction

  // Round half up and drop 15 fraction bits.
  function automatic longint drop_q15(longint v);
    return (v + cpct_pkg::ROUND_Q15) >>> 15;
  endfunction

  function automatic longint clamp_sample(longint v);
    longint hi;
    hi = (64'sd1 <<< (cpct_pkg::SAMPLE_BITS - 1)) - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < -hi - 1) begin
      return -hi - 1;
    end
    return v;
  endfunction

  // Expected d/q currents for one sample beat.
  function automatic dq_t rotate_currents(sample_t s);
    longint a;
    longint b;
    longint beta;
    longint sn;
    longint cs;
    longint dv;
    longint qv;
    int     p;
    dq_t    r;
    a    = longint'(s.phase_a);
    b    = longint'(s.phase_b);
    p    = (int'(s.angle) * 4 * DEPTH) >> 16;
    sn   = sine_at_step(p);
    cs   = sine_at_step((p + DEPTH) % (4 * DEPTH));
    beta = drop_q15((a + 2 * b) * longint'(cpct_pkg::INV_SQRT3_Q15));
    dv   = clamp_sample(drop_q15(a * cs + beta * sn));
    qv   = clamp_sample(drop_q15(beta * cs - a * sn));
    r.d_current = dv[15:0];
    r.q_current = qv[15:0];
    return r;
  endfunction

  function automatic sample_t make_sample(int a, int b, int ang);
    sample_t s;
    s.phase_a = a[15:0];
    s.phase_b = b[15:0];
    s.angle   = ang[15:0];
    return s;
  endfunction

  // Currents lean on the rails and near zero now and then.
  function automatic int pick_current();
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2: v = int'($urandom_range(16)) - 8;
      default: v = int'($urandom_range(65535));
    endcase
    return v;
  endfunction

  // Angles sometimes sit close to a quadrant boundary.
  function automatic int pick_angle();
    int v;
    if ($urandom_range(7) == 0) begin
      v = (int'($urandom_range(3)) << 14) + int'($urandom_range(63)) - 32;
    end else begin
      v = int'($urandom_range(65535));
    end
    return v & 16'hffff;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: a new beat is loaded once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        dq_expected.push_back(rotate_currents(sample_t'(in_tdata)));
        if (dq_expected[$].d_current == 16'sh7fff || dq_expected[$].d_current == 16'sh8000 ||
            dq_expected[$].q_current == 16'sh7fff || dq_expected[$].q_current == 16'sh8000) begin
          rail_hits++;
        end
        beats_in++;
      end
      if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= samples_to_send.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off during the full-rate phase, so the pipeline backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rst_n && beats_in == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: check each result beat against the oldest prediction.
  always @(posedge clk) begin
    dq_t got;
    dq_t want;
    if (out_tvalid && out_tready) begin
      got = dq_t'(out_tdata);
      beats_out++;
      if (dq_expected.size() == 0) begin
        flag_error($sformatf("unexpected result d=%0d q=%0d", got.d_current, got.q_current));
      end else begin
        want = dq_expected.pop_front();
        if (got.d_current != want.d_current) begin
          flag_error($sformatf("beat %0d d_current expected %0d got %0d",
                               beats_out - 1, want.d_current, got.d_current));
        end
        if (got.q_current != want.q_current) begin
          flag_error($sformatf("beat %0d q_current expected %0d got %0d",
                               beats_out - 1, want.q_current, got.q_current));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int i;
    for (i = 0; i <= DEPTH; i++) begin
      quarter_wave[i] = quarter_sine(i);
    end

    // Directed beats: rails, quadrant edges, saturation and small negatives.
    samples_to_send.push_back(make_sample(0, 0, 0));
    samples_to_send.push_back(make_sample(32767, 0, 0));
    samples_to_send.push_back(make_sample(-32768, 0, 0));
    samples_to_send.push_back(make_sample(32767, 32767, 10923));
    samples_to_send.push_back(make_sample(-32768, -32768, 10923));
    samples_to_send.push_back(make_sample(32767, 32767, 16384));
    samples_to_send.push_back(make_sample(32767, 32767, 49152));
    samples_to_send.push_back(make_sample(32767, -32768, 0));
    samples_to_send.push_back(make_sample(-32768, 32767, 32768));
    samples_to_send.push_back(make_sample(-32768, -32768, 65535));
    samples_to_send.push_back(make_sample(12345, -6789, 16383));
    samples_to_send.push_back(make_sample(12345, -6789, 16384));
    samples_to_send.push_back(make_sample(12345, -6789, 32767));
    samples_to_send.push_back(make_sample(12345, -6789, 32768));
    samples_to_send.push_back(make_sample(12345, -6789, 49151));
    samples_to_send.push_back(make_sample(12345, -6789, 49152));
    samples_to_send.push_back(make_sample(12345, -6789, 65535));
    samples_to_send.push_back(make_sample(-1, 0, 0));
    samples_to_send.push_back(make_sample(0, -1, 0));
    samples_to_send.push_back(make_sample(1, 0, 8192));
    samples_to_send.push_back(make_sample(-3, 1, 21845));
    samples_to_send.push_back(make_sample(-1, -1, 40000));

    // Random beats.
    for (i = 0; i < RANDOM_BEATS; i++) begin
      samples_to_send.push_back(make_sample(pick_current(), pick_current(), pick_angle()));
    end
    total_beats = samples_to_send.size();
    hold_at = total_beats - 300;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (dq_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats (%0d directed) under three idle profiles and one long stall.",
             beats_in, total_beats - RANDOM_BEATS);
    $display("Checked %0d d/q result beats, %0d of them on a saturation rail; %0d errors.",
             beats_out, rail_hits, error_count);
    if (error_count == 0 && dq_expected.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cpct_pkg.sv
hw/rtl/clarke_park_current_transform.sv
sim/testbench.sv
